### rtl/fwu_pkg.sv
// ----------------------------------------------------------------------------
// Firmware update package
// Shared types, command/status/state codes for the firmware update block.
// ----------------------------------------------------------------------------
`default_nettype none

package fwu_pkg;

  // URI length limit in bytes
  localparam int unsigned URI_MAX_LEN = 255;

  // Command codes
  localparam logic [2:0] CMD_PKG_CHUNK  = 3'd0;
  localparam logic [2:0] CMD_URI_CHUNK  = 3'd1;
  localparam logic [2:0] CMD_EXECUTE    = 3'd2;
  localparam logic [2:0] CMD_DL_RESULT  = 3'd3;
  localparam logic [2:0] CMD_UPD_RESULT = 3'd4;

  // Status codes
  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_BAD_REQUEST = 3'd1;
  localparam logic [2:0] ST_NOT_ALLOWED = 3'd2;
  localparam logic [2:0] ST_INTERNAL    = 3'd3;
  localparam logic [2:0] ST_REJECTED    = 3'd4;

  // Update states
  localparam logic [1:0] FW_IDLE        = 2'd0;
  localparam logic [1:0] FW_DOWNLOADING = 2'd1;
  localparam logic [1:0] FW_DOWNLOADED  = 2'd2;
  localparam logic [1:0] FW_UPDATING    = 2'd3;

  // Handler result codes
  localparam logic [3:0] CODE_INITIAL = 4'd0;
  localparam logic [3:0] CODE_SUCCESS = 4'd1;
  localparam logic [3:0] CODE_FAILED  = 4'd8;

  // Delivery method codes
  localparam logic [1:0] DM_PULL = 2'd0;
  localparam logic [1:0] DM_PUSH = 2'd1;
  localparam logic [1:0] DM_BOTH = 2'd2;

  // Configuration register indexes (word address bit)
  localparam logic CFG_PUSH_EN = 1'b0;
  localparam logic CFG_PULL_EN = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] chunk_offset;
    logic [15:0] chunk_size;
    logic [31:0] total_length;
    logic        first_byte_zero;
    logic [3:0]  start_status;
    logic [3:0]  data_status;
    logic [3:0]  finish_status;
  } fwu_item_t;

  typedef struct packed {
    logic [1:0]  fw_state;
    logic [3:0]  last_result;
    logic        start_done;
    logic [31:0] package_count;
    logic [7:0]  uri_count;
  } fwu_state_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] update_state;
    logic [3:0] result_code;
    logic       reset_pulse;
    logic [1:0] delivery_method;
  } fwu_result_t;

  typedef struct packed {
    logic push_enabled;
    logic pull_enabled;
  } fwu_cfg_t;

endpackage

`default_nettype wire

### rtl/fwu_core.sv
// ----------------------------------------------------------------------------
// Firmware update event logic
// Combinational next-state and result for one event against the current state.
// ----------------------------------------------------------------------------
`default_nettype none

module fwu_core (
  input  wire fwu_pkg::fwu_item_t   item,
  input  wire fwu_pkg::fwu_state_t  st,
  input  wire fwu_pkg::fwu_cfg_t    cfg,
  output fwu_pkg::fwu_state_t       st_nxt,
  output fwu_pkg::fwu_result_t      res
);

  logic [32:0] end_pos;     // offset + length, no wrap
  logic        end_is_total;
  logic        pkg_rst_req;
  logic        uri_rst_req;
  logic        uri_too_long;
  logic        pkg_in_order;
  logic        uri_in_order;
  logic [2:0]  status;
  logic        pulse;

  // Shared compares
  assign end_pos      = {1'b0, item.chunk_offset} + {17'b0, item.chunk_size};
  assign end_is_total = (end_pos == {1'b0, item.total_length});
  assign pkg_rst_req  = (item.total_length == 32'd1) && (item.chunk_offset == 32'd0)
                        && item.first_byte_zero;
  assign uri_rst_req  = (item.total_length == 32'd0) && (item.chunk_offset == 32'd0)
                        && (item.chunk_size == 16'd0);
  assign uri_too_long = (end_pos > 33'(fwu_pkg::URI_MAX_LEN))
                        || (item.total_length > 32'(fwu_pkg::URI_MAX_LEN));
  assign pkg_in_order = (st.package_count == item.chunk_offset);
  assign uri_in_order = ({24'b0, st.uri_count} == item.chunk_offset);

  // Event decode
  always_comb begin
    st_nxt = st;
    status = fwu_pkg::ST_OK;
    pulse  = 1'b0;
    unique case (item.command)
      fwu_pkg::CMD_PKG_CHUNK: begin
        priority if (!cfg.push_enabled) begin
          status = fwu_pkg::ST_BAD_REQUEST;
        end else if (st.fw_state == fwu_pkg::FW_UPDATING) begin
          status = fwu_pkg::ST_NOT_ALLOWED;
        end else if (pkg_rst_req) begin
          st_nxt.fw_state      = fwu_pkg::FW_IDLE;
          st_nxt.start_done    = 1'b0;
          st_nxt.package_count = '0;
          st_nxt.uri_count     = '0;
          pulse                = 1'b1;
        end else if (st.fw_state != fwu_pkg::FW_IDLE) begin
          status = fwu_pkg::ST_NOT_ALLOWED;
        end else if (!st.start_done && (item.start_status != fwu_pkg::CODE_SUCCESS)) begin
          st_nxt.last_result = item.start_status;
          status             = fwu_pkg::ST_INTERNAL;
        end else if (!pkg_in_order) begin
          // start handler ran even though the offset is off
          st_nxt.start_done = 1'b1;
          status            = fwu_pkg::ST_BAD_REQUEST;
        end else if ((item.data_status != fwu_pkg::CODE_SUCCESS)
                     || (end_is_total && (item.finish_status != fwu_pkg::CODE_SUCCESS))) begin
          st_nxt.last_result   = (item.data_status != fwu_pkg::CODE_SUCCESS)
                                 ? item.data_status : item.finish_status;
          st_nxt.fw_state      = fwu_pkg::FW_IDLE;
          st_nxt.start_done    = 1'b0;
          st_nxt.package_count = '0;
          st_nxt.uri_count     = '0;
          pulse                = 1'b1;
          status               = fwu_pkg::ST_INTERNAL;
        end else begin
          st_nxt.start_done    = 1'b1;
          st_nxt.package_count = st.package_count + {16'b0, item.chunk_size};
          if (end_is_total) begin
            st_nxt.fw_state = fwu_pkg::FW_DOWNLOADED;
          end
        end
      end
      fwu_pkg::CMD_URI_CHUNK: begin
        priority if (!cfg.pull_enabled) begin
          status = fwu_pkg::ST_BAD_REQUEST;
        end else if (st.fw_state == fwu_pkg::FW_UPDATING) begin
          status = fwu_pkg::ST_NOT_ALLOWED;
        end else if (uri_rst_req) begin
          st_nxt.fw_state      = fwu_pkg::FW_IDLE;
          st_nxt.start_done    = 1'b0;
          st_nxt.package_count = '0;
          st_nxt.uri_count     = '0;
          pulse                = 1'b1;
        end else if (st.fw_state != fwu_pkg::FW_IDLE) begin
          status = fwu_pkg::ST_NOT_ALLOWED;
        end else if (uri_too_long || !uri_in_order) begin
          status = fwu_pkg::ST_BAD_REQUEST;
        end else begin
          st_nxt.uri_count = st.uri_count + item.chunk_size[7:0];
          if (end_is_total) begin
            if (item.data_status != fwu_pkg::CODE_SUCCESS) begin
              st_nxt.last_result = item.data_status;
              status             = fwu_pkg::ST_BAD_REQUEST;
            end else begin
              st_nxt.fw_state = fwu_pkg::FW_DOWNLOADING;
            end
          end
        end
      end
      fwu_pkg::CMD_EXECUTE: begin
        priority if (st.fw_state != fwu_pkg::FW_DOWNLOADED) begin
          status = fwu_pkg::ST_NOT_ALLOWED;
        end else if (item.start_status != fwu_pkg::CODE_SUCCESS) begin
          st_nxt.last_result = fwu_pkg::CODE_FAILED;
          st_nxt.fw_state    = fwu_pkg::FW_IDLE;
          status             = fwu_pkg::ST_INTERNAL;
        end else begin
          st_nxt.fw_state = fwu_pkg::FW_UPDATING;
        end
      end
      fwu_pkg::CMD_DL_RESULT: begin
        priority if (st.fw_state != fwu_pkg::FW_DOWNLOADING) begin
          status = fwu_pkg::ST_REJECTED;
        end else if (item.data_status != fwu_pkg::CODE_SUCCESS) begin
          st_nxt.last_result   = item.data_status;
          st_nxt.fw_state      = fwu_pkg::FW_IDLE;
          st_nxt.start_done    = 1'b0;
          st_nxt.package_count = '0;
          st_nxt.uri_count     = '0;
          pulse                = 1'b1;
        end else begin
          st_nxt.fw_state = fwu_pkg::FW_DOWNLOADED;
        end
      end
      fwu_pkg::CMD_UPD_RESULT: begin
        st_nxt.last_result   = item.data_status;
        st_nxt.fw_state      = fwu_pkg::FW_IDLE;
        st_nxt.start_done    = 1'b0;
        st_nxt.package_count = '0;
      end
      default: begin
        status = fwu_pkg::ST_NOT_ALLOWED;
      end
    endcase
  end

  // Result beat
  always_comb begin
    res.status       = status;
    res.update_state = st_nxt.fw_state;
    res.result_code  = st_nxt.last_result;
    res.reset_pulse  = pulse;
    priority if (cfg.push_enabled && cfg.pull_enabled) begin
      res.delivery_method = fwu_pkg::DM_BOTH;
    end else if (cfg.push_enabled) begin
      res.delivery_method = fwu_pkg::DM_PUSH;
    end else begin
      res.delivery_method = fwu_pkg::DM_PULL;
    end
  end

endmodule

`default_nettype wire

### rtl/firmware_update_state_machine.sv
// ----------------------------------------------------------------------------
// Firmware update state machine
// Tracks the firmware update object state across chunk writes, execute and
// result reports; one result beat per event.
//
//   Channel  Direction  Handshake          Payload
//   in_      input      in_valid/in_stall  command, offsets, lengths, codes
//   out_     output     out_valid/out_stall status, state, result, pulse, method
//   cfg      APB        psel/penable       push/pull enable at 0x0 / 0x4
//
// An event goes into an input register, is decoded combinationally and lands
// in the result register; one event per cycle is sustained while out_stall is
// low, set by the single decode stage that updates the state registers.
// rst_n (synchronous) returns to idle with both enables set and no beats held.
// out_stall holds the result register; in_stall rises only once the input
// register also holds an event that cannot move on.
// ----------------------------------------------------------------------------
`default_nettype none

module firmware_update_state_machine (
  input  wire         clk,
  input  wire         rst_n,
  // event channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [2:0]  in_command,
  input  wire  [31:0] in_chunk_offset,
  input  wire  [15:0] in_chunk_size,
  input  wire  [31:0] in_total_length,
  input  wire         in_first_byte_zero,
  input  wire  [3:0]  in_start_status,
  input  wire  [3:0]  in_data_status,
  input  wire  [3:0]  in_finish_status,
  // result channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic [2:0]  out_status,
  output logic [1:0]  out_update_state,
  output logic [3:0]  out_result_code,
  output logic        out_reset_pulse,
  output logic [1:0]  out_delivery_method,
  // configuration port
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fwu_pkg::fwu_item_t   item_r;
  logic                 item_vld_r;
  fwu_pkg::fwu_state_t  st_r;
  fwu_pkg::fwu_state_t  st_nxt;
  fwu_pkg::fwu_result_t res_nxt;
  fwu_pkg::fwu_result_t res_r;
  logic                 res_vld_r;
  fwu_pkg::fwu_cfg_t    cfg_r;
  logic                 adv;
  logic                 in_take;
  logic                 cfg_wr;

  // Pipeline movement
  assign adv      = !res_vld_r || !out_stall;
  assign in_stall = item_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (!in_stall) begin
      item_vld_r <= in_valid;
    end
    if (in_take) begin
      item_r.command         <= in_command;
      item_r.chunk_offset    <= in_chunk_offset;
      item_r.chunk_size      <= in_chunk_size;
      item_r.total_length    <= in_total_length;
      item_r.first_byte_zero <= in_first_byte_zero;
      item_r.start_status    <= in_start_status;
      item_r.data_status     <= in_data_status;
      item_r.finish_status   <= in_finish_status;
    end
  end

  fwu_core u_core (
    .item   (item_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.fw_state      <= fwu_pkg::FW_IDLE;
      st_r.last_result   <= fwu_pkg::CODE_INITIAL;
      st_r.start_done    <= 1'b0;
      st_r.package_count <= '0;
      st_r.uri_count     <= '0;
      res_vld_r          <= 1'b0;
    end else if (adv) begin
      res_vld_r <= item_vld_r;
      if (item_vld_r) begin
        st_r <= st_nxt;
      end
    end
    if (adv && item_vld_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = res_vld_r;
  assign out_status          = res_r.status;
  assign out_update_state    = res_r.update_state;
  assign out_result_code     = res_r.result_code;
  assign out_reset_pulse     = res_r.reset_pulse;
  assign out_delivery_method = res_r.delivery_method;

  // Configuration registers; word address picks the register
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.push_enabled <= 1'b1;
      cfg_r.pull_enabled <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        fwu_pkg::CFG_PUSH_EN: cfg_r.push_enabled <= pwdata[0];
        fwu_pkg::CFG_PULL_EN: cfg_r.pull_enabled <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fwu_pkg::CFG_PUSH_EN: prdata = {31'b0, cfg_r.push_enabled};
      fwu_pkg::CFG_PULL_EN: prdata = {31'b0, cfg_r.pull_enabled};
      default:              prdata = '0;
    endcase
  end

  // low address bits and pwdata above bit 0 carry nothing for these registers
  logic unused_ok;
  assign unused_ok = &{1'b0, paddr[1:0], pwdata[31:1]};

endmodule

`default_nettype wire

### sim/tb_firmware_update_state_machine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Firmware update state machine testbench
// Drives event beats through the valid/stall channel and predicts every reply
// beat with a behavioural copy of the update state, result code and byte
// counters. Each reply is compared field by field, in order. A directed pass
// covers the corner cases, then the delivery enables are swept over the APB
// port, the reply side is held off long enough to back the block up, and a
// long run of mostly well-formed download sequences finishes the job.
// ----------------------------------------------------------------------------
module tb_firmware_update_state_machine;
  import fwu_pkg::*;

  // Command codes the block does not decode
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  localparam int RANDOM_EVENTS = 1150;
  localparam int DRAIN_LIMIT   = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  // event channel
  logic        in_valid = 1'b0;
  logic        in_stall;
  fwu_item_t   in_beat = '0;

  // reply channel
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [1:0]  out_update_state;
  logic [3:0]  out_result_code;
  logic        out_reset_pulse;
  logic [1:0]  out_delivery_method;

  // APB port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // behavioural copy of the block
  fwu_state_t  fw_model;
  fwu_cfg_t    cfg_model;
  fwu_result_t predicted_replies[$];

  // run control and statistics
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int          hold_request = 0;
  int          error_count = 0;
  int          events_sent = 0;
  int          replies_checked = 0;
  int          updates_started = 0;
  int          stalled_cycles = 0;

  firmware_update_state_machine dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_beat.command),
    .in_chunk_offset     (in_beat.chunk_offset),
    .in_chunk_size       (in_beat.chunk_size),
    .in_total_length     (in_beat.total_length),
    .in_first_byte_zero  (in_beat.first_byte_zero),
    .in_start_status     (in_beat.start_status),
    .in_data_status      (in_beat.data_status),
    .in_finish_status    (in_beat.finish_status),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_update_state    (out_update_state),
    .out_result_code     (out_result_code),
    .out_reset_pulse     (out_reset_pulse),
    .out_delivery_method (out_delivery_method),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction: apply one event to the model, return the reply it causes
  // --------------------------------------------------------------------------
  function automatic fwu_result_t apply_event(fwu_item_t ev);
    fwu_result_t res;
    logic [32:0] chunk_end;
    logic        wiped;
    chunk_end  = {1'b0, ev.chunk_offset} + 33'(ev.chunk_size);
    wiped      = 1'b0;
    res.status = ST_OK;
    case (ev.command)
      CMD_PKG_CHUNK: begin
        if (!cfg_model.push_enabled) res.status = ST_BAD_REQUEST;
        else if (fw_model.fw_state == FW_UPDATING) res.status = ST_NOT_ALLOWED;
        else if (ev.total_length == 32'd1 && ev.chunk_offset == '0 && ev.first_byte_zero)
          wiped = 1'b1;
        else if (fw_model.fw_state != FW_IDLE) res.status = ST_NOT_ALLOWED;
        else if (!fw_model.start_done && ev.start_status != CODE_SUCCESS) begin
          fw_model.last_result = ev.start_status;
          res.status = ST_INTERNAL;
        end else begin
          fw_model.start_done = 1'b1;
          if (fw_model.package_count != ev.chunk_offset) res.status = ST_BAD_REQUEST;
          else if (ev.data_status != CODE_SUCCESS) begin
            fw_model.last_result = ev.data_status;
            wiped = 1'b1;
            res.status = ST_INTERNAL;
          end else begin
            fw_model.package_count = fw_model.package_count + 32'(ev.chunk_size);
            // last chunk runs the finish handler
            if (chunk_end == {1'b0, ev.total_length}) begin
              if (ev.finish_status != CODE_SUCCESS) begin
                fw_model.last_result = ev.finish_status;
                wiped = 1'b1;
                res.status = ST_INTERNAL;
              end else begin
                fw_model.fw_state = FW_DOWNLOADED;
              end
            end
          end
        end
      end
      CMD_URI_CHUNK: begin
        if (!cfg_model.pull_enabled) res.status = ST_BAD_REQUEST;
        else if (fw_model.fw_state == FW_UPDATING) res.status = ST_NOT_ALLOWED;
        else if (ev.total_length == '0 && ev.chunk_offset == '0 && ev.chunk_size == '0)
          wiped = 1'b1;
        else if (fw_model.fw_state != FW_IDLE) res.status = ST_NOT_ALLOWED;
        else if (chunk_end > 33'(URI_MAX_LEN) || ev.total_length > URI_MAX_LEN)
          res.status = ST_BAD_REQUEST;
        else if ({24'd0, fw_model.uri_count} != ev.chunk_offset) res.status = ST_BAD_REQUEST;
        else begin
          fw_model.uri_count = fw_model.uri_count + ev.chunk_size[7:0];
          if (chunk_end == {1'b0, ev.total_length}) begin
            if (ev.data_status != CODE_SUCCESS) begin
              fw_model.last_result = ev.data_status;
              res.status = ST_BAD_REQUEST;
            end else begin
              fw_model.fw_state = FW_DOWNLOADING;
            end
          end
        end
      end
      CMD_EXECUTE: begin
        if (fw_model.fw_state != FW_DOWNLOADED) res.status = ST_NOT_ALLOWED;
        else if (ev.start_status != CODE_SUCCESS) begin
          fw_model.last_result = CODE_FAILED;
          fw_model.fw_state = FW_IDLE;
          res.status = ST_INTERNAL;
        end else begin
          fw_model.fw_state = FW_UPDATING;
          updates_started++;
        end
      end
      CMD_DL_RESULT: begin
        if (fw_model.fw_state != FW_DOWNLOADING) res.status = ST_REJECTED;
        else if (ev.data_status != CODE_SUCCESS) begin
          fw_model.last_result = ev.data_status;
          wiped = 1'b1;
        end else begin
          fw_model.fw_state = FW_DOWNLOADED;
        end
      end
      CMD_UPD_RESULT: begin
        fw_model.last_result   = ev.data_status;
        fw_model.fw_state      = FW_IDLE;
        fw_model.start_done    = 1'b0;
        fw_model.package_count = '0;
      end
      default: res.status = ST_NOT_ALLOWED;
    endcase

    // machine reset keeps the result code
    if (wiped) begin
      fw_model.fw_state      = FW_IDLE;
      fw_model.start_done    = 1'b0;
      fw_model.package_count = '0;
      fw_model.uri_count     = '0;
    end

    res.update_state = fw_model.fw_state;
    res.result_code  = fw_model.last_result;
    res.reset_pulse  = wiped;
    if (cfg_model.push_enabled && cfg_model.pull_enabled) res.delivery_method = DM_BOTH;
    else if (cfg_model.push_enabled) res.delivery_method = DM_PUSH;
    else res.delivery_method = DM_PULL;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  // idle run length: mostly none, some short, a few long
  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // handler code, mostly success
  function automatic logic [3:0] rand_code();
    if ($urandom_range(0, 99) < 85) return CODE_SUCCESS;
    return 4'($urandom_range(0, 9));
  endfunction

  function automatic fwu_item_t make_event(logic [2:0] cmd, logic [31:0] off,
                                           logic [15:0] len, logic [31:0] total,
                                           logic fbz, logic [3:0] ss,
                                           logic [3:0] ds, logic [3:0] fs);
    fwu_item_t ev;
    ev.command         = cmd;
    ev.chunk_offset    = off;
    ev.chunk_size      = len;
    ev.total_length    = total;
    ev.first_byte_zero = fbz;
    ev.start_status    = ss;
    ev.data_status     = ds;
    ev.finish_status   = fs;
    return ev;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // one event beat; valid stays up while stalled, prediction at acceptance
  task automatic send_event(fwu_item_t ev);
    int gap;
    gap = gaps_on ? pick_idle_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= ev;
    do @(posedge clk); while (in_stall);
    predicted_replies.push_back(apply_event(ev));
    events_sent++;
  endtask

  // wait for every predicted reply, then let the pipeline settle
  task automatic drain_replies();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (predicted_replies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (predicted_replies.size() != 0) begin
      $error("%0d predicted replies never arrived", predicted_replies.size());
      error_count++;
      predicted_replies.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup then access, then back to idle
  task automatic write_register(logic reg_sel, logic value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= {31'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == CFG_PUSH_EN) cfg_model.push_enabled = value;
    else cfg_model.pull_enabled = value;
    @(posedge clk);
  endtask

  task automatic set_delivery(logic push_en, logic pull_en);
    drain_replies();
    write_register(CFG_PUSH_EN, push_en);
    write_register(CFG_PULL_EN, pull_en);
  endtask

  // --------------------------------------------------------------------------
  // Event sequences
  // --------------------------------------------------------------------------
  // update result then URI reset: back to idle, counters cleared when pull is enabled
  task automatic return_to_idle();
    send_event(make_event(CMD_UPD_RESULT, 32'($urandom), 16'($urandom), 32'($urandom),
                          1'($urandom), 4'($urandom_range(0, 9)),
                          4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))));
    send_event(make_event(CMD_URI_CHUNK, '0, '0, '0, 1'($urandom), rand_code(),
                          rand_code(), rand_code()));
  endtask

  task automatic finish_update();
    if ($urandom_range(0, 99) < 90)
      send_event(make_event(CMD_EXECUTE, 32'($urandom), 16'($urandom), 32'($urandom),
                            1'($urandom), rand_code(), rand_code(), rand_code()));
    if ($urandom_range(0, 99) < 85)
      send_event(make_event(CMD_UPD_RESULT, '0, '0, '0, 1'b0, rand_code(),
                            4'($urandom_range(0, 9)), rand_code()));
  endtask

  // push delivery: consecutive package chunks, occasionally a broken offset
  task automatic run_package_download();
    int          n_chunks;
    logic [15:0] lens[4];
    logic [31:0] total;
    logic [31:0] off;
    n_chunks = $urandom_range(1, 4);
    total = '0;
    for (int i = 0; i < n_chunks; i++) begin
      lens[i] = ($urandom_range(0, 19) == 0) ? 16'hFFFF : 16'($urandom_range(0, 1500));
      total += 32'(lens[i]);
    end
    off = '0;
    for (int i = 0; i < n_chunks; i++) begin
      if ($urandom_range(0, 99) < 5) off += 32'($urandom_range(1, 9));
      send_event(make_event(CMD_PKG_CHUNK, off, lens[i], total, 1'($urandom),
                            rand_code(), rand_code(), rand_code()));
      off += 32'(lens[i]);
    end
    finish_update();
  endtask

  // pull delivery: URI chunks, download result, then the update
  task automatic run_uri_download();
    int          n_chunks;
    int          remaining;
    int          len;
    logic [31:0] total;
    logic [31:0] off;
    total = 32'($urandom_range(1, URI_MAX_LEN));
    n_chunks = $urandom_range(1, 3);
    remaining = int'(total);
    off = '0;
    for (int i = 0; i < n_chunks; i++) begin
      len = (i == n_chunks - 1) ? remaining : $urandom_range(0, remaining);
      if ($urandom_range(0, 99) < 4) len += $urandom_range(1, 40);
      send_event(make_event(CMD_URI_CHUNK, off, 16'(len), total, 1'($urandom),
                            rand_code(), rand_code(), rand_code()));
      off += 32'(len);
      remaining -= (len > remaining) ? remaining : len;
    end
    send_event(make_event(CMD_DL_RESULT, '0, '0, '0, 1'b0, rand_code(), rand_code(),
                          rand_code()));
    finish_update();
  endtask

  // unconstrained beat, commands 0 to 7
  task automatic send_noise();
    logic [31:0] off;
    logic [31:0] total;
    logic [15:0] len;
    off   = ($urandom_range(0, 1) == 1) ? 32'($urandom) : 32'($urandom_range(0, 300));
    total = ($urandom_range(0, 1) == 1) ? 32'($urandom) : 32'($urandom_range(0, 300));
    len   = ($urandom_range(0, 1) == 1) ? 16'($urandom) : 16'($urandom_range(0, 300));
    send_event(make_event(3'($urandom_range(0, 7)), off, len, total, 1'($urandom),
                          4'($urandom_range(0, 9)), 4'($urandom_range(0, 9)),
                          4'($urandom_range(0, 9))));
  endtask

  task automatic run_mixed_traffic(int count);
    int target;
    int r;
    target = events_sent + count;
    while (events_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 70 && $urandom_range(0, 99) < 80) return_to_idle();
      if (r < 40) run_package_download();
      else if (r < 70) run_uri_download();
      else if (r < 90) repeat ($urandom_range(1, 4)) send_noise();
      else if (r < 95)
        send_event(make_event(CMD_PKG_CHUNK, '0, 16'($urandom), 32'd1, 1'b1,
                              rand_code(), rand_code(), rand_code()));
      else
        send_event(make_event(CMD_URI_CHUNK, '0, '0, '0, 1'($urandom), rand_code(),
                              rand_code(), rand_code()));
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_corner_cases();
    // undecoded commands with every payload bit set and clear, execute and report in idle
    send_event(make_event(CMD_RSVD7, '1, '1, '1, 1'b1, 4'hF, 4'hF, 4'hF));
    send_event(make_event(CMD_RSVD5, '0, '0, '0, 1'b0, '0, '0, '0));
    send_event(make_event(CMD_EXECUTE, '0, '0, '0, 1'b0, CODE_SUCCESS, CODE_SUCCESS,
                          CODE_SUCCESS));
    send_event(make_event(CMD_DL_RESULT, '0, '0, '0, 1'b0, CODE_SUCCESS, CODE_SUCCESS,
                          CODE_SUCCESS));
    // write start failure, then a good chunk, an out-of-order offset and a data failure
    send_event(make_event(CMD_PKG_CHUNK, '0, 16'd10, 32'd20, 1'b0, 4'd3, CODE_SUCCESS,
                          CODE_SUCCESS));
    send_event(make_event(CMD_PKG_CHUNK, '0, 16'd10, 32'd20, 1'b0, CODE_SUCCESS,
                          CODE_SUCCESS, CODE_SUCCESS));
    send_event(make_event(CMD_PKG_CHUNK, 32'd5, 16'd10, 32'd20, 1'b0, CODE_SUCCESS,
                          CODE_SUCCESS, CODE_SUCCESS));
    send_event(make_event(CMD_PKG_CHUNK, 32'd10, 16'd10, 32'd20, 1'b0, CODE_SUCCESS,
                          4'd4, CODE_SUCCESS));
    // finish failure, then a full-length single chunk
    send_event(make_event(CMD_PKG_CHUNK, '0, 16'd8, 32'd8, 1'b0, CODE_SUCCESS,
                          CODE_SUCCESS, 4'd6));
    send_event(make_event(CMD_PKG_CHUNK, '0, 16'hFFFF, 32'h0000_FFFF, 1'b0, CODE_SUCCESS,
                          CODE_SUCCESS, CODE_SUCCESS));
    send_event(make_event(CMD_PKG_CHUNK, '0, 16'd1, 32'd2, 1'b0, CODE_SUCCESS,
                          CODE_SUCCESS, CODE_SUCCESS));
    // update start failure keeps the counters; an empty chunk completes again
    send_event(make_event(CMD_EXECUTE, '0, '0, '0, 1'b0, 4'd2, CODE_SUCCESS,
                          CODE_SUCCESS));
    send_event(make_event(CMD_PKG_CHUNK, 32'h0000_FFFF, '0, 32'h0000_FFFF, 1'b0,
                          CODE_SUCCESS, CODE_SUCCESS, CODE_SUCCESS));
    send_event(make_event(CMD_EXECUTE, '0, '0, '0, 1'b0, CODE_SUCCESS, CODE_SUCCESS,
                          CODE_SUCCESS));
    // reset requests refused while updating
    send_event(make_event(CMD_PKG_CHUNK, '0, 16'd1, 32'd1, 1'b1, CODE_SUCCESS,
                          CODE_SUCCESS, CODE_SUCCESS));
    send_event(make_event(CMD_URI_CHUNK, '0, '0, '0, 1'b0, CODE_SUCCESS, CODE_SUCCESS,
                          CODE_SUCCESS));
    send_event(make_event(CMD_UPD_RESULT, '0, '0, '0, 1'b0, CODE_SUCCESS, 4'd9,
                          CODE_SUCCESS));
    send_event(make_event(CMD_PKG_CHUNK, '0, 16'd1, 32'd1, 1'b1, CODE_SUCCESS,
                          CODE_SUCCESS, CODE_SUCCESS));
    // URI: a good chunk, an overlong chunk, overlong total, handler failure on the last chunk
    send_event(make_event(CMD_URI_CHUNK, '0, 16'd200, 32'd255, 1'b0, CODE_SUCCESS,
                          CODE_SUCCESS, CODE_SUCCESS));
    send_event(make_event(CMD_URI_CHUNK, 32'd200, 16'd56, 32'd255, 1'b0, CODE_SUCCESS,
                          CODE_SUCCESS, CODE_SUCCESS));
    send_event(make_event(CMD_URI_CHUNK, '0, 16'd1, 32'd300, 1'b0, CODE_SUCCESS,
                          CODE_SUCCESS, CODE_SUCCESS));
    send_event(make_event(CMD_URI_CHUNK, 32'd200, 16'd55, 32'd255, 1'b0, CODE_SUCCESS,
                          4'd5, CODE_SUCCESS));
    // URI reset, full-length URI, failing download report
    send_event(make_event(CMD_URI_CHUNK, '0, '0, '0, 1'b1, CODE_SUCCESS, CODE_SUCCESS,
                          CODE_SUCCESS));
    send_event(make_event(CMD_URI_CHUNK, '0, 16'd255, 32'd255, 1'b0, CODE_SUCCESS,
                          CODE_SUCCESS, CODE_SUCCESS));
    send_event(make_event(CMD_DL_RESULT, '0, '0, '0, 1'b0, CODE_SUCCESS, 4'd7,
                          CODE_SUCCESS));
    // top offset with nothing written, then a short pull that succeeds
    send_event(make_event(CMD_PKG_CHUNK, '1, '1, '1, 1'b0, CODE_SUCCESS, CODE_SUCCESS,
                          CODE_SUCCESS));
    send_event(make_event(CMD_URI_CHUNK, '0, 16'd10, 32'd10, 1'b0, CODE_SUCCESS,
                          CODE_SUCCESS, CODE_SUCCESS));
    send_event(make_event(CMD_DL_RESULT, '0, '0, '0, 1'b0, CODE_SUCCESS, CODE_SUCCESS,
                          CODE_SUCCESS));
    drain_replies();
  endtask

  // every combination of the enables, neither one first
  task automatic test_delivery_enables();
    set_delivery(1'b0, 1'b0);
    run_mixed_traffic(25);
    set_delivery(1'b1, 1'b0);
    run_mixed_traffic(25);
    set_delivery(1'b0, 1'b1);
    run_mixed_traffic(25);
    set_delivery(1'b1, 1'b1);
    run_mixed_traffic(25);
    drain_replies();
  endtask

  // long reply hold-off while events keep coming
  task automatic test_backpressure();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    hold_request = 80;
    run_mixed_traffic(40);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    drain_replies();
  endtask

  task automatic test_random_traffic();
    run_mixed_traffic(RANDOM_EVENTS / 2);
    // a stretch at full rate on both sides
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    run_mixed_traffic(200);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    run_mixed_traffic(RANDOM_EVENTS / 2 - 200);
    drain_replies();
  endtask

  // --------------------------------------------------------------------------
  // Reply side: stall generator and checker
  // --------------------------------------------------------------------------
  initial begin : reply_stall_gen
    int   run_len;
    logic stall_now;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_now = 1'b1;
        run_len = hold_request;
        hold_request = 0;
      end else if (stalls_on) begin
        stall_now = ($urandom_range(0, 99) < 30);
        run_len = stall_now ? pick_idle_len() + 1 : $urandom_range(1, 6);
      end else begin
        stall_now = 1'b0;
        run_len = 1;
      end
      out_stall <= stall_now;
      repeat (run_len - 1) @(posedge clk);
    end
  end

  always @(posedge clk) begin : reply_check
    fwu_result_t want;
    if (rst_n && in_valid && in_stall) stalled_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_replies.size() == 0) begin
        $error("reply beat with no prediction waiting");
        error_count++;
      end else begin
        want = predicted_replies.pop_front();
        check_field("status", 32'(want.status), 32'(out_status));
        check_field("update_state", 32'(want.update_state), 32'(out_update_state));
        check_field("result_code", 32'(want.result_code), 32'(out_result_code));
        check_field("reset_pulse", 32'(want.reset_pulse), 32'(out_reset_pulse));
        check_field("delivery_method", 32'(want.delivery_method),
                    32'(out_delivery_method));
        replies_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence of tests
  // --------------------------------------------------------------------------
  initial begin
    fw_model = '0;
    cfg_model.push_enabled = 1'b1;
    cfg_model.pull_enabled = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_corner_cases();
    test_delivery_enables();
    test_backpressure();
    test_random_traffic();
    repeat (10) @(posedge clk);

    $display("Covered %0d events and %0d checked replies, %0d updates started.",
             events_sent, replies_checked, updates_started);
    $display("All delivery enable settings used; input held by the block for %0d cycles.",
             stalled_cycles);
    if (error_count == 0) begin
      $display("firmware_update_state_machine regression: pass");
    end else begin
      $display("firmware_update_state_machine regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6000000;
    $display("firmware_update_state_machine regression: fail");
    $finish;
  end

endmodule

### firmware_update_state_machine.f
rtl/fwu_pkg.sv
rtl/fwu_core.sv
rtl/firmware_update_state_machine.sv
sim/tb_firmware_update_state_machine.sv
